// ===== rtl/url_percent_encoder_assert.svh =====
// Assertion macros shared by the URL encoder RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef URL_PERCENT_ENCODER_ASSERT_SVH
`define URL_PERCENT_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/urlpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent encoder package
// Section codes, queue entry format and byte classification helpers.
// ----------------------------------------------------------------------------
package urlpe_pkg;

    typedef enum logic [2:0] {
        SEC_SCHEME = 3'd0,
        SEC_HOST   = 3'd1,
        SEC_PATH   = 3'd2,
        SEC_QUERY  = 3'd3,
        SEC_FRAG   = 3'd4
    } section_t;

    // Most bytes one input byte can produce
    localparam int MaxEmit = 7;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;

    // Upper-case hex digits, index 0 in the low byte
    localparam logic [15:0][7:0] HexUpper = "FEDCBA9876543210";

    // "%25", first byte in the low lane
    localparam logic [2:0][7:0] PctEsc = {8'h35, 8'h32, CH_PCT};

    // One queue entry: the encoded bytes produced by one input byte
    typedef struct packed {
        logic [MaxEmit-1:0][7:0] data;
        logic [2:0]              count;
        logic                    fin;
    } emit_t;

    // Outcome of one ordinary byte with nothing held
    typedef struct packed {
        section_t        sec;
        logic [1:0]      match;
        logic            hold;
        logic [2:0][7:0] data;
        logic [1:0]      count;
    } proc_t;

    function automatic logic is_hex(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_unres(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
               c == "-" || c == "." || c == "_" || c == "~";
    endfunction

    function automatic logic query_safe(logic [7:0] c);
        return is_unres(c) || c == "&" || c == "=" || c == ";" || c == ":" || c == "," ||
               c == "+" || c == "/" || c == "@" || c == "?";
    endfunction

    function automatic logic frag_safe(logic [7:0] c);
        return is_unres(c) || c == "/" || c == "?" || c == "&" || c == "=";
    endfunction

    function automatic proc_t proc_byte(section_t sec, logic [1:0] match, logic [7:0] c);
        proc_t           r;
        logic [1:0]      m;
        logic [7:0]      sep;
        logic [2:0][7:0] enc;
        logic            keep;
        r.sec   = sec;
        r.match = match;
        r.hold  = 1'b0;
        r.data  = {8'h00, 8'h00, c};
        r.count = 2'd1;
        enc     = {HexUpper[c[3:0]], HexUpper[c[7:4]], CH_PCT};
        sep     = (match == 2'd0) ? CH_COLON : CH_SLASH;
        m       = (c == sep) ? match + 2'd1 : ((c == CH_COLON) ? 2'd1 : 2'd0);
        keep    = 1'b1;
        case (sec)
            SEC_SCHEME:
            begin
                if (m == 2'd3)
                begin
                    r.sec   = SEC_HOST;
                    r.match = 2'd0;
                end
                else
                begin
                    r.match = m;
                end
            end
            SEC_HOST:
            begin
                if (c == CH_SLASH)
                    r.sec = SEC_PATH;
                else if (c == CH_QMARK)
                    r.sec = SEC_QUERY;
                else if (c == CH_HASH)
                    r.sec = SEC_FRAG;
            end
            SEC_PATH:
            begin
                if (c == CH_QMARK)
                    r.sec = SEC_QUERY;
                else if (c == CH_HASH)
                    r.sec = SEC_FRAG;
                else if (c == CH_PCT)
                    r.hold = 1'b1;
                else
                    keep = (c == CH_SLASH) || is_unres(c);
            end
            SEC_QUERY:
            begin
                if (c == CH_HASH)
                    r.sec = SEC_FRAG;
                else if (c == CH_PCT)
                    r.hold = 1'b1;
                else
                    keep = query_safe(c);
            end
            default:
            begin
                if (c == CH_PCT)
                    r.hold = 1'b1;
                else
                    keep = frag_safe(c);
            end
        endcase
        if (r.hold)
        begin
            r.count = 2'd0;
        end
        else if (!keep)
        begin
            r.data  = enc;
            r.count = 2'd3;
        end
        return r;
    endfunction

endpackage

// ===== rtl/urlpe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL encoder front end
// Accepts input bytes, tracks section and escape state, and builds the list
// of output bytes for each accepted byte.
// ----------------------------------------------------------------------------
module urlpe_front
    import urlpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       in_final,
    output logic       push,
    output emit_t      push_entry
);

    `include "url_percent_encoder_assert.svh"

    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    section_t   sec_reg,   sec_next;
    logic [1:0] match_reg, match_next;
    logic [1:0] held_reg,  held_next;
    logic [7:0] digit_reg, digit_next;

    logic                    accept;
    proc_t                   r_cur;
    proc_t                   r_dig;
    proc_t                   r_aft;
    logic [MaxEmit-1:0][7:0] obytes;
    logic [2:0]              ocnt;

    function automatic logic [MaxEmit-1:0][7:0] append_bytes(
        logic [MaxEmit-1:0][7:0] bytes_in,
        logic [2:0]              n,
        logic [2:0][7:0]         d,
        logic [1:0]              k
    );
        logic [MaxEmit-1:0][7:0] b;
        logic [3:0]              pos;
        b = bytes_in;
        for (int i = 0; i < 3; i++)
        begin
            pos = {1'b0, n} + 4'(i);
            if (2'(i) < k && pos < 4'(MaxEmit))
                b[pos[2:0]] = d[i];
        end
        return b;
    endfunction

    assign accept = in_valid && in_ready;

    // r_dig/r_aft: replay of the held digit, then the current byte
    assign r_cur = proc_byte(sec_reg, match_reg, in_char);
    assign r_dig = proc_byte(sec_reg, match_reg, digit_reg);
    assign r_aft = proc_byte(r_dig.sec, r_dig.match, in_char);

    always_comb
    begin
        obytes     = '0;
        ocnt       = 3'd0;
        sec_next   = sec_reg;
        match_next = match_reg;
        held_next  = held_reg;
        digit_next = digit_reg;
        case (held_reg)
            HELD_PCT:
            begin
                if (is_hex(in_char))
                begin
                    held_next  = HELD_DIGIT;
                    digit_next = in_char;
                end
                else
                begin
                    obytes     = append_bytes(obytes, ocnt, PctEsc, 2'd3);
                    ocnt       = ocnt + 3'd3;
                    obytes     = append_bytes(obytes, ocnt, r_cur.data, r_cur.count);
                    ocnt       = ocnt + {1'b0, r_cur.count};
                    sec_next   = r_cur.sec;
                    match_next = r_cur.match;
                    held_next  = r_cur.hold ? HELD_PCT : HELD_NONE;
                end
            end
            HELD_DIGIT:
            begin
                if (is_hex(in_char))
                begin
                    obytes    = append_bytes(obytes, ocnt, {in_char, digit_reg, CH_PCT}, 2'd3);
                    ocnt      = 3'd3;
                    held_next = HELD_NONE;
                end
                else
                begin
                    obytes     = append_bytes(obytes, ocnt, PctEsc, 2'd3);
                    ocnt       = ocnt + 3'd3;
                    obytes     = append_bytes(obytes, ocnt, r_dig.data, r_dig.count);
                    ocnt       = ocnt + {1'b0, r_dig.count};
                    obytes     = append_bytes(obytes, ocnt, r_aft.data, r_aft.count);
                    ocnt       = ocnt + {1'b0, r_aft.count};
                    sec_next   = r_aft.sec;
                    match_next = r_aft.match;
                    held_next  = r_aft.hold ? HELD_PCT : HELD_NONE;
                end
            end
            default:
            begin
                obytes     = append_bytes(obytes, ocnt, r_cur.data, r_cur.count);
                ocnt       = {1'b0, r_cur.count};
                sec_next   = r_cur.sec;
                match_next = r_cur.match;
                held_next  = r_cur.hold ? HELD_PCT : HELD_NONE;
            end
        endcase

        // End of string: flush whatever is held, then back to reset state
        if (in_final)
        begin
            if (held_next == HELD_PCT || held_next == HELD_DIGIT)
            begin
                obytes = append_bytes(obytes, ocnt, PctEsc, 2'd3);
                ocnt   = ocnt + 3'd3;
            end
            if (held_next == HELD_DIGIT)
            begin
                obytes = append_bytes(obytes, ocnt, {8'h00, 8'h00, digit_next}, 2'd1);
                ocnt   = ocnt + 3'd1;
            end
            sec_next   = SEC_SCHEME;
            match_next = 2'd0;
            held_next  = HELD_NONE;
            digit_next = 8'h00;
        end
    end

    assign push             = accept && (ocnt != 3'd0);
    assign push_entry.data  = obytes;
    assign push_entry.count = ocnt;
    assign push_entry.fin   = in_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg   <= SEC_SCHEME;
            match_reg <= 2'd0;
            held_reg  <= HELD_NONE;
            digit_reg <= 8'h00;
        end
        else if (accept)
        begin
            sec_reg   <= sec_next;
            match_reg <= match_next;
            held_reg  <= held_next;
            digit_reg <= digit_next;
        end
    end

    `ASSERT_NEXT(a_fin_resets, accept && in_final,
        sec_reg == SEC_SCHEME && held_reg == HELD_NONE && match_reg == 2'd0,
        "state not cleared after end of string")
    `ASSERT_IMPLIES(a_fin_emits, accept && in_final, push,
        "end of string produced no output")

endmodule

// ===== rtl/urlpe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL encoder queue
// Small FIFO of encoded byte groups between the front and back ends.
// ----------------------------------------------------------------------------
module urlpe_queue
    import urlpe_pkg::*;
#(
    parameter int Depth = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  emit_t push_entry,
    output logic  ready,
    input  logic  pop,
    output logic  head_valid,
    output emit_t head
);

    `include "url_percent_encoder_assert.svh"

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

    emit_t mem [Depth];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg,  count_next;

    assign ready      = (count_reg != DepthCnt);
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, push, ready, "push into full queue")
    `ASSERT_IMPLIES(a_no_underflow, pop, head_valid, "pop from empty queue")

endmodule

// ===== rtl/urlpe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL encoder back end
// Walks the queue head one byte per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module urlpe_back
    import urlpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  emit_t      head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       run_end,
    output logic       string_end
);

    `include "url_percent_encoder_assert.svh"

    logic       valid_reg, valid_next;
    logic [2:0] idx_reg,   idx_next;
    logic [7:0] char_reg;
    logic       run_end_reg;
    logic       string_end_reg;

    logic load;
    logic is_last;

    assign load    = head_valid && (!valid_reg || out_ready);
    assign is_last = (idx_reg == head.count - 3'd1);
    assign pop     = load && is_last;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? 3'd0 : idx_reg + 3'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg       <= head.data[idx_reg];
            run_end_reg    <= is_last;
            string_end_reg <= is_last && head.fin;
        end
    end

    assign out_valid  = valid_reg;
    assign out_char   = char_reg;
    assign run_end    = run_end_reg;
    assign string_end = string_end_reg;

    `ASSERT_IMPLIES(a_idx_in_range, head_valid, idx_reg < head.count,
        "byte index past end of queue entry")
    `ASSERT_NEXT(a_idx_steps, load && !is_last, idx_reg != 3'd0,
        "byte index did not advance within an entry")

endmodule

// ===== rtl/url_percent_encoder.sv =====
`timescale 1ns / 1ps
// Each accepted input byte's output bytes enter the byte-group queue as one entry,
// then move from its head into the output register. Throughput: one output byte per
// cycle while the output is not stalled; an input byte is taken every cycle while the
// queue (QDepth entries) has room, and a byte expanding to n bytes holds the back end.
// Reset: section tracking, escape state, queue and output register are cleared.
// ----------------------------------------------------------------------------
// URL percent encoder
// Streams URL bytes in and emits the percent-encoded string, one byte per beat.
// ----------------------------------------------------------------------------
module url_percent_encoder
    import urlpe_pkg::*;
#(
    parameter int QDepth = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  logic       s_axis_tlast,   // in_final
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast,   // string_end
    output logic [0:0] m_axis_tuser    // [0] run_end
);

    logic  push;
    emit_t push_entry;
    logic  q_ready;
    logic  pop;
    logic  head_valid;
    emit_t head;

    assign s_axis_tready = q_ready;

    urlpe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (q_ready),
        .in_char    (s_axis_tdata),
        .in_final   (s_axis_tlast),
        .push       (push),
        .push_entry (push_entry)
    );

    urlpe_queue #(
        .Depth (QDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .ready      (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    urlpe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_char   (m_axis_tdata),
        .run_end    (m_axis_tuser[0]),
        .string_end (m_axis_tlast)
    );

endmodule

// ===== test/tb_url_percent_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent encoder testbench
// Streams URL strings into the encoder one byte per transaction. A behavioral
// predictor tracks the section, the scheme separator and any held escape, and
// works out the encoded bytes. Each output transaction is checked in order.
// A short directed table comes first, then random URLs and noise strings.
// Both sides idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_url_percent_encoder
    import urlpe_pkg::*;
();

    localparam int WatchdogLimit = 2000;
    localparam int RandItems     = 240;
    localparam int QuietItems    = 40;
    localparam int DrainCycles   = 20;
    localparam int DirRows       = 23;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       str_end;
    } enc_out_t;

    // typed = 1: expected bytes given in txt, first byte in the highest lane used
    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic        typed;
        logic [2:0]  n;
        logic [55:0] txt;
    } dir_row_t;

    localparam dir_row_t DirTab [DirRows] = '{
        '{"x",   1'b1, 1'b1, 3'd1, "x"},        // single byte string, scheme copy
        '{8'h01, 1'b1, 1'b1, 3'd1, 56'h01},     // lowest nonzero byte
        '{"h",   1'b0, 1'b1, 3'd1, "h"},
        '{":",   1'b0, 1'b1, 3'd1, ":"},
        '{"/",   1'b0, 1'b1, 3'd1, "/"},
        '{"/",   1'b0, 1'b1, 3'd1, "/"},        // separator done, host follows
        '{"H",   1'b0, 1'b1, 3'd1, "H"},
        '{"/",   1'b0, 1'b1, 3'd1, "/"},        // opens path
        '{8'hFF, 1'b0, 1'b1, 3'd3, "%FF"},      // highest byte
        '{"%",   1'b0, 1'b1, 3'd0, ""},
        '{"4",   1'b0, 1'b1, 3'd0, ""},
        '{"a",   1'b0, 1'b1, 3'd3, "%4a"},      // confirmed escape
        '{"%",   1'b0, 1'b1, 3'd0, ""},
        '{"g",   1'b0, 1'b1, 3'd4, "%25g"},     // escape fails on first byte
        '{"%",   1'b0, 1'b1, 3'd0, ""},
        '{"3",   1'b0, 1'b1, 3'd0, ""},
        '{" ",   1'b0, 1'b1, 3'd7, "%253%20"},  // escape fails on second byte
        '{"?",   1'b0, 1'b0, 3'd0, ""},
        '{"@",   1'b0, 1'b0, 3'd0, ""},
        '{"#",   1'b0, 1'b1, 3'd1, "#"},
        '{"^",   1'b0, 1'b1, 3'd3, "%5E"},
        '{"%",   1'b0, 1'b1, 3'd0, ""},
        '{"e",   1'b1, 1'b1, 3'd4, "%25e"}      // end of string flushes the hold
    };

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [0:0] m_axis_tuser;

    // predictor state
    section_t   sec_st    = SEC_SCHEME;
    logic [1:0] colon_cnt = 2'd0;
    logic [1:0] held_n    = 2'd0;
    logic [7:0] held_ch   = 8'h00;

    logic [7:0] step_out[$];
    enc_out_t   expected_out[$];
    logic [7:0] url_q[$];

    bit idle_on    = 1'b1;
    int err_cnt    = 0;
    int out_cnt    = 0;
    int in_cnt     = 0;
    int rand_items = 0;
    int string_cnt = 0;
    int stall_left = 0;
    int quiet_cyc  = 0;

    string alnum_set  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    string punct_set  = "-._~/&=;:,+@!$*'()[] <>\"";
    string hex_set    = "0123456789abcdefABCDEF";
    string nonhex_set = "gGzZ_~. /!";
    string noise_set  = ":/?#%aZ9";

    url_percent_encoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] in_char
        .s_axis_tlast  (s_axis_tlast),   // in_final
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_char
        .m_axis_tlast  (m_axis_tlast),   // string_end
        .m_axis_tuser  (m_axis_tuser)    // [0] run_end
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] hex_ascii(logic [3:0] nib);
        return (nib < 4'd10) ? ("0" + {4'h0, nib}) : ("A" - 8'd10 + {4'h0, nib});
    endfunction

    function automatic bit hex_digit_ok(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit unreserved(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
               c == "-" || c == "." || c == "_" || c == "~";
    endfunction

    function automatic bit query_keep(logic [7:0] c);
        return unreserved(c) || c == "&" || c == "=" || c == ";" || c == ":" || c == "," ||
               c == "+" || c == "/" || c == "@" || c == "?";
    endfunction

    function automatic bit frag_keep(logic [7:0] c);
        return unreserved(c) || c == "/" || c == "?" || c == "&" || c == "=";
    endfunction

    task automatic push_escaped(input logic [7:0] b);
        step_out.push_back("%");
        step_out.push_back(hex_ascii(b[7:4]));
        step_out.push_back(hex_ascii(b[3:0]));
    endtask

    // one byte with nothing held
    task automatic encode_plain(input logic [7:0] c);
        logic [7:0] sep;
        sep = (colon_cnt == 2'd0) ? ":" : "/";
        case (sec_st)
            SEC_SCHEME:
            begin
                step_out.push_back(c);
                if (c == sep)
                    colon_cnt = colon_cnt + 2'd1;
                else
                    colon_cnt = (c == ":") ? 2'd1 : 2'd0;
                if (colon_cnt == 2'd3)
                begin
                    sec_st    = SEC_HOST;
                    colon_cnt = 2'd0;
                end
            end
            SEC_HOST:
            begin
                if (c == "/")
                    sec_st = SEC_PATH;
                else if (c == "?")
                    sec_st = SEC_QUERY;
                else if (c == "#")
                    sec_st = SEC_FRAG;
                step_out.push_back(c);
            end
            SEC_PATH:
            begin
                if (c == "?")
                begin
                    sec_st = SEC_QUERY;
                    step_out.push_back(c);
                end
                else if (c == "#")
                begin
                    sec_st = SEC_FRAG;
                    step_out.push_back(c);
                end
                else if (c == "%")
                    held_n = 2'd1;
                else if (c == "/" || unreserved(c))
                    step_out.push_back(c);
                else
                    push_escaped(c);
            end
            SEC_QUERY:
            begin
                if (c == "#")
                begin
                    sec_st = SEC_FRAG;
                    step_out.push_back(c);
                end
                else if (c == "%")
                    held_n = 2'd1;
                else if (query_keep(c))
                    step_out.push_back(c);
                else
                    push_escaped(c);
            end
            default:
            begin
                if (c == "%")
                    held_n = 2'd1;
                else if (frag_keep(c))
                    step_out.push_back(c);
                else
                    push_escaped(c);
            end
        endcase
    endtask

    task automatic encode_byte(input logic [7:0] c, input logic fin);
        step_out.delete();
        if (held_n == 2'd1)
        begin
            if (hex_digit_ok(c))
            begin
                held_ch = c;
                held_n  = 2'd2;
            end
            else
            begin
                held_n = 2'd0;
                push_escaped("%");
                encode_plain(c);
            end
        end
        else if (held_n == 2'd2)
        begin
            if (hex_digit_ok(c))
            begin
                step_out.push_back("%");
                step_out.push_back(held_ch);
                step_out.push_back(c);
                held_n = 2'd0;
            end
            else
            begin
                held_n = 2'd0;
                push_escaped("%");
                encode_plain(held_ch);
                encode_plain(c);
            end
        end
        else
            encode_plain(c);
        if (fin)
        begin
            if (held_n != 2'd0)
                push_escaped("%");
            if (held_n == 2'd2)
                step_out.push_back(held_ch);
            sec_st    = SEC_SCHEME;
            colon_cnt = 2'd0;
            held_n    = 2'd0;
            held_ch   = 8'h00;
        end
    endtask

    task automatic queue_expected(input logic fin);
        enc_out_t e;
        for (int k = 0; k < step_out.size(); k++)
        begin
            e.ch      = step_out[k];
            e.run_end = (k == step_out.size() - 1);
            e.str_end = e.run_end && fin;
            expected_out.push_back(e);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic add_body_piece();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            url_q.push_back(pick(alnum_set));
        else if (r < 55)
            url_q.push_back(pick(punct_set));
        else if (r < 70)
            url_q.push_back(8'($urandom_range(1, 255)));
        else if (r < 80)
        begin
            url_q.push_back("%");
            url_q.push_back(pick(hex_set));
            url_q.push_back(pick(hex_set));
        end
        else if (r < 85)
        begin
            url_q.push_back("%");
            url_q.push_back(pick(hex_set));
            url_q.push_back(pick(nonhex_set));
        end
        else if (r < 89)
        begin
            url_q.push_back("%");
            if ($urandom_range(0, 1) == 0)
                url_q.push_back(pick(nonhex_set));
        end
        else if (r < 93)
            url_q.push_back("?");
        else if (r < 96)
            url_q.push_back("#");
        else
            url_q.push_back("/");
    endtask

    // mostly well-formed URLs; some noise with no usable scheme
    task automatic make_url();
        int n;
        url_q.delete();
        if ($urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 8);
            repeat (n)
            begin
                if ($urandom_range(0, 1) == 0)
                    url_q.push_back(pick(noise_set));
                else
                    url_q.push_back(8'($urandom_range(1, 255)));
            end
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n) url_q.push_back(pick(alnum_set));
            url_q.push_back(":");
            url_q.push_back("/");
            url_q.push_back("/");
            n = $urandom_range(1, 5);
            repeat (n)
            begin
                if ($urandom_range(0, 7) == 0)
                    url_q.push_back(8'($urandom_range(1, 255)));
                else
                    url_q.push_back(pick(alnum_set));
            end
            if ($urandom_range(0, 5) != 0)
            begin
                case ($urandom_range(0, 3))
                    0:       url_q.push_back("?");
                    1:       url_q.push_back("#");
                    default: url_q.push_back("/");
                endcase
                n = $urandom_range(0, 10);
                repeat (n) add_body_piece();
            end
        end
    endtask

    // returns in the time step of the accepting edge
    task automatic send_byte(input logic [7:0] c, input logic fin);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        in_cnt++;
    endtask

    initial
    begin
        logic fin;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DirRows; r++)
        begin
            send_byte(DirTab[r].ch, DirTab[r].fin);
            encode_byte(DirTab[r].ch, DirTab[r].fin);
            if (DirTab[r].typed)
            begin
                step_out.delete();
                for (int k = int'(DirTab[r].n) - 1; k >= 0; k--)
                    step_out.push_back(DirTab[r].txt[k*8 +: 8]);
            end
            queue_expected(DirTab[r].fin);
            if (DirTab[r].fin)
                string_cnt++;
        end

        while (rand_items < RandItems)
        begin
            make_url();
            for (int i = 0; i < url_q.size(); i++)
            begin
                idle_on = (rand_items < RandItems - QuietItems);
                fin     = (i == url_q.size() - 1);
                send_byte(url_q[i], fin);
                encode_byte(url_q[i], fin);
                queue_expected(fin);
                rand_items++;
            end
            string_cnt++;
        end
        s_axis_tvalid <= 1'b0;

        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Run covered %0d strings, %0d input bytes (%0d directed, %0d random)",
                 string_cnt, in_cnt, DirRows, rand_items);
        $display("Checked %0d encoded output bytes, %0d mismatches", out_cnt, err_cnt);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: back-pressure and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (err_cnt < 100)
            $display("MISMATCH at output byte %0d: %s got %h expected %h",
                     out_cnt, what, got, want);
        err_cnt++;
    endtask

    task automatic check_output();
        enc_out_t e;
        if (expected_out.size() == 0)
            report_mismatch("unexpected transaction, out_char", m_axis_tdata, 8'h00);
        else
        begin
            e = expected_out.pop_front();
            if (m_axis_tdata !== e.ch)
                report_mismatch("out_char", m_axis_tdata, e.ch);
            if (m_axis_tuser[0] !== e.run_end)
                report_mismatch("run_end", {7'h0, m_axis_tuser[0]}, {7'h0, e.run_end});
            if (m_axis_tlast !== e.str_end)
                report_mismatch("string_end", {7'h0, m_axis_tlast}, {7'h0, e.str_end});
        end
        out_cnt++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_output();
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 14);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cyc = 0;
            else
                quiet_cyc++;
            if (quiet_cyc >= WatchdogLimit)
            begin
                $display("Watchdog: no transaction for %0d cycles, %0d bytes still expected",
                         quiet_cyc, expected_out.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
